// ===== hw/rtl/blake2s_256_hash_unit_macros.svh =====
// Assertion macros shared by the checker.
`ifndef BLAKE2S_256_HASH_UNIT_MACROS_SVH
`define BLAKE2S_256_HASH_UNIT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define B2S_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define B2S_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== hw/rtl/b2s_pkg.sv =====
package b2s_pkg;

  localparam logic [31:0] PARAM_WORD = 32'h01010020;

  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [3:0] SIGMA [10][16] = '{
    '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15},
    '{14, 10, 4, 8, 9, 15, 13, 6, 1, 12, 0, 2, 11, 7, 5, 3},
    '{11, 8, 12, 0, 5, 2, 15, 13, 10, 14, 3, 6, 7, 1, 9, 4},
    '{7, 9, 3, 1, 13, 12, 11, 14, 2, 6, 5, 10, 4, 0, 15, 8},
    '{9, 0, 5, 7, 2, 4, 10, 15, 14, 1, 11, 12, 6, 8, 3, 13},
    '{2, 12, 6, 10, 0, 11, 8, 3, 4, 13, 7, 5, 15, 14, 1, 9},
    '{12, 5, 1, 15, 14, 13, 4, 10, 0, 7, 6, 3, 9, 2, 8, 11},
    '{13, 11, 7, 14, 12, 1, 3, 9, 5, 0, 15, 4, 8, 6, 2, 10},
    '{6, 15, 14, 9, 11, 3, 0, 8, 12, 2, 13, 7, 1, 4, 10, 5},
    '{10, 2, 8, 4, 7, 6, 1, 5, 15, 11, 9, 14, 3, 12, 13, 0}
  };

  typedef enum logic [2:0] {
    ST_IDLE, ST_PAD, ST_INIT, ST_ROUND, ST_FOLD, ST_OUT
  } state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic       take_byte;   // store data byte at fill position
    logic       pad_byte;    // write zero at fill position
    logic       add_block;   // byte_total += 64, fill = 0
    logic       add_fill;    // byte_total += fill, plus one if a byte is taken
    logic       init_v;      // load working vector
    logic       final_flag;  // invert v14 at init
    logic       do_g;        // one G step
    logic       fold;        // chain ^= v lo ^ v hi
    logic       reset_state; // back to initial chain
  } cmd_t;

  typedef struct packed {
    logic [6:0] fill;
  } status_t;

  function automatic logic [31:0] ror32(input logic [31:0] v, input int n);
    ror32 = (v >> n) | (v << (32 - n));
  endfunction

endpackage

// ===== hw/rtl/b2s_ctrl.sv =====
module b2s_ctrl
  import b2s_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        byte_present,
  input  logic        last,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [2:0]  word_index,
  output logic        last_word,
  input  status_t     sts,
  output cmd_t        cmd,
  output logic [3:0]  round_idx,
  output logic [2:0]  g_idx
);

  state_t     state, state_next;
  logic       final_run, final_run_next;
  logic       pend_byte, pend_byte_next;
  logic       pend_last, pend_last_next;
  logic [3:0] round_next;
  logic [2:0] g_next, widx_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      final_run <= 1'b0;
      pend_byte <= 1'b0;
      pend_last <= 1'b0;
      round_idx <= '0;
      g_idx <= '0;
      word_index <= '0;
    end else begin
      state <= state_next;
      final_run <= final_run_next;
      pend_byte <= pend_byte_next;
      pend_last <= pend_last_next;
      round_idx <= round_next;
      g_idx <= g_next;
      word_index <= widx_next;
    end
  end

  always_comb begin
    state_next = state;
    final_run_next = final_run;
    pend_byte_next = pend_byte;
    pend_last_next = pend_last;
    round_next = round_idx;
    g_next = g_idx;
    widx_next = word_index;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    last_word = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (byte_present && sts.fill[6]) begin
            // Full block waits for one more byte: compress it first.
            pend_byte_next = 1'b1;
            pend_last_next = last;
            final_run_next = 1'b0;
            state_next = ST_INIT;
          end else begin
            cmd.take_byte = byte_present;
            // The message length is counted before padding moves the fill.
            cmd.add_fill = last;
            if (last) state_next = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (sts.fill[6]) begin
          final_run_next = 1'b1;
          state_next = ST_INIT;
        end else begin
          cmd.pad_byte = 1'b1;
        end
      end
      ST_INIT: begin
        cmd.init_v = 1'b1;
        cmd.final_flag = final_run;
        cmd.add_block = !final_run;
        round_next = '0;
        g_next = '0;
        state_next = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.do_g = 1'b1;
        g_next = g_idx + 3'd1;
        if (g_idx == 3'd7) begin
          round_next = round_idx + 4'd1;
          if (round_idx == 4'd9) state_next = ST_FOLD;
        end
      end
      ST_FOLD: begin
        cmd.fold = 1'b1;
        widx_next = '0;
        if (final_run) begin
          state_next = ST_OUT;
        end else begin
          // Replay the held byte into the emptied block.
          cmd.take_byte = pend_byte;
          cmd.add_fill = pend_last;
          pend_byte_next = 1'b0;
          state_next = pend_last ? ST_PAD : ST_IDLE;
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        last_word = (word_index == 3'd7);
        if (out_ready) begin
          widx_next = word_index + 3'd1;
          if (word_index == 3'd7) begin
            cmd.reset_state = 1'b1;
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/b2s_datapath.sv =====
module b2s_datapath
  import b2s_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  input  logic [7:0]  data_byte,
  input  logic        use_held,
  input  logic [3:0]  round_idx,
  input  logic [2:0]  g_idx,
  input  logic [2:0]  word_index,
  output status_t     sts,
  output logic [31:0] digest_word
);

  logic [31:0] h [8];
  logic [31:0] v [16];
  // Message block kept as sixteen little-endian words, filled a byte at a time.
  logic [31:0] blk [16];
  logic [63:0] total;
  logic [6:0]  fill;
  logic [7:0]  held;

  assign sts.fill = fill;
  assign digest_word = h[word_index];

  // G operand indexes for the current step.
  logic [3:0] ia, ib, ic, id;
  logic [1:0] col;
  always_comb begin
    col = g_idx[1:0];
    ia = {2'b00, col};
    if (!g_idx[2]) begin
      ib = 4'd4 + {2'b00, col};
      ic = 4'd8 + {2'b00, col};
      id = 4'd12 + {2'b00, col};
    end else begin
      ib = {2'b01, col + 2'd1};
      ic = {2'b10, col + 2'd2};
      id = {2'b11, col + 2'd3};
    end
  end

  logic [3:0]  sx, sy;
  logic [31:0] mx, my;
  logic [31:0] a1, d1, c1, b1, a2, d2, c2, b2;
  always_comb begin
    sx = SIGMA[round_idx][{g_idx, 1'b0}];
    sy = SIGMA[round_idx][{g_idx, 1'b1}];
    mx = blk[sx];
    my = blk[sy];
    a1 = v[ia] + v[ib] + mx;
    d1 = ror32(v[id] ^ a1, 16);
    c1 = v[ic] + d1;
    b1 = ror32(v[ib] ^ c1, 12);
    a2 = a1 + b1 + my;
    d2 = ror32(d1 ^ a2, 8);
    c2 = c1 + d2;
    b2 = ror32(b1 ^ c2, 7);
  end

  logic [7:0] wbyte;
  assign wbyte = use_held ? held : data_byte;

  always_ff @(posedge clk) begin
    if (cmd.take_byte || cmd.pad_byte)
      blk[fill[5:2]][{fill[1:0], 3'b000} +: 8] <= cmd.pad_byte ? 8'h00 : wbyte;
    if (!use_held) held <= data_byte;
    if (cmd.init_v) begin
      for (int i = 0; i < 8; i++) v[i] <= h[i];
      for (int i = 0; i < 4; i++) v[i + 8] <= IV[i];
      v[12] <= IV[4] ^ (cmd.add_block ? total[31:0] + 32'd64 : total[31:0]);
      v[13] <= IV[5] ^ (cmd.add_block ? total[63:32] + 32'(total[31:0] > 32'hffffffbf)
                                      : total[63:32]);
      v[14] <= cmd.final_flag ? ~IV[6] : IV[6];
      v[15] <= IV[7];
    end
    if (cmd.do_g) begin
      v[ia] <= a2;
      v[ib] <= b2;
      v[ic] <= c2;
      v[id] <= d2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.reset_state) begin
      h[0] <= IV[0] ^ PARAM_WORD;
      for (int i = 1; i < 8; i++) h[i] <= IV[i];
      total <= '0;
      fill <= '0;
    end else begin
      if (cmd.init_v && cmd.add_block) begin
        total <= total + 64'd64;
        fill <= '0;
      end else if (cmd.take_byte || cmd.pad_byte) begin
        fill <= fill + 7'd1;
      end
      if (cmd.add_fill) total <= total + 64'(fill) + 64'(cmd.take_byte);
      if (cmd.fold)
        for (int i = 0; i < 8; i++) h[i] <= h[i] ^ v[i] ^ v[i + 8];
    end
  end

endmodule

// ===== hw/rtl/blake2s_256_hash_unit.sv =====
// BLAKE2s-256 (unkeyed) hash unit. Each input request carries at most one
// message byte and a last marker; bytes are accepted one per cycle while
// the unit is idle and the block buffer has room. When a 65th byte
// arrives after a full block, that block is compressed first: one shared
// G unit runs 80 steps (10 rounds of 8 G mixes) plus init and fold, and
// no request is accepted meanwhile. On a last request the block is
// zero-padded one byte per cycle, compressed with the final flag, and the
// digest is then delivered as eight 32-bit little-endian words,
// word_index 0 to 7 with last_word on the eighth.
// After the eighth word is taken the unit returns to its initial state.
module blake2s_256_hash_unit
  import b2s_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        byte_present,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);

  cmd_t       cmd;
  status_t    sts;
  logic [3:0] round_idx;
  logic [2:0] g_idx;

  b2s_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .byte_present, .last,
    .out_ready, .out_valid, .word_index, .last_word,
    .sts, .cmd, .round_idx, .g_idx
  );

  // While idle the incoming byte is latched, so a deferred byte is replayed
  // from the holding register once the compression is done.
  b2s_datapath u_dp (
    .clk, .rst, .cmd, .data_byte, .use_held(!in_ready),
    .round_idx, .g_idx, .word_index, .sts, .digest_word
  );

endmodule

// ===== hw/rtl/b2s_checker.sv =====
`include "blake2s_256_hash_unit_macros.svh"
module b2s_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  word_index,
  input logic        last_word
);
  `B2S_ASSERT_IMP(a_no_overlap, out_valid, !in_ready, "input open during digest")
  `B2S_ASSERT_IMP(a_last_word, out_valid, last_word == (word_index == 3'd7), "last_word")
  `B2S_ASSERT_NEXT(a_idx_step, out_valid && out_ready && !last_word,
    out_valid && word_index == $past(word_index) + 3'd1, "word order")
  `B2S_ASSERT_NEXT(a_hold, out_valid && !out_ready,
    out_valid && $stable(word_index), "stalled word moved")
endmodule

bind blake2s_256_hash_unit b2s_checker u_chk (
  .clk, .rst, .in_ready, .out_valid, .out_ready, .word_index, .last_word
);

// ===== tb/blake2s_256_hash_unit_test.sv =====
module blake2s_256_hash_unit_test;
  import b2s_pkg::*;

  // Scoreboard that keeps its own BLAKE2s state and the queue of pending
  // digest words. Each accepted request is folded into the running hash.
  class digest_scoreboard;
    logic [31:0] chain [8];
    logic [7:0]  block_buf [64];
    logic [63:0] byte_total;
    int unsigned fill;
    logic [31:0] word_q [$];
    logic [2:0]  index_q [$];
    int          errors;

    function new();
      errors = 0;
      restart();
    endfunction

    function void restart();
      for (int i = 0; i < 8; i++) chain[i] = IV[i];
      chain[0] = chain[0] ^ PARAM_WORD;
      byte_total = '0;
      fill = 0;
    endfunction

    function logic [31:0] rotr(logic [31:0] v, int n);
      return (v >> n) | (v << (32 - n));
    endfunction

    function void compress(bit is_final);
      logic [31:0] m [16];
      logic [31:0] v [16];
      int a [8];
      int b [8];
      int c [8];
      int d [8];
      a = '{0, 1, 2, 3, 0, 1, 2, 3};
      b = '{4, 5, 6, 7, 5, 6, 7, 4};
      c = '{8, 9, 10, 11, 10, 11, 8, 9};
      d = '{12, 13, 14, 15, 15, 12, 13, 14};
      for (int i = 0; i < 16; i++)
        m[i] = {block_buf[4*i+3], block_buf[4*i+2], block_buf[4*i+1], block_buf[4*i]};
      for (int i = 0; i < 8; i++) begin
        v[i] = chain[i];
        v[i+8] = IV[i];
      end
      v[12] = v[12] ^ byte_total[31:0];
      v[13] = v[13] ^ byte_total[63:32];
      if (is_final) v[14] = ~v[14];
      for (int r = 0; r < 10; r++) begin
        for (int g = 0; g < 8; g++) begin
          v[a[g]] = v[a[g]] + v[b[g]] + m[SIGMA[r][2*g]];
          v[d[g]] = rotr(v[d[g]] ^ v[a[g]], 16);
          v[c[g]] = v[c[g]] + v[d[g]];
          v[b[g]] = rotr(v[b[g]] ^ v[c[g]], 12);
          v[a[g]] = v[a[g]] + v[b[g]] + m[SIGMA[r][2*g+1]];
          v[d[g]] = rotr(v[d[g]] ^ v[a[g]], 8);
          v[c[g]] = v[c[g]] + v[d[g]];
          v[b[g]] = rotr(v[b[g]] ^ v[c[g]], 7);
        end
      end
      for (int i = 0; i < 8; i++) chain[i] = chain[i] ^ v[i] ^ v[i+8];
    endfunction

    function void note_request(logic [7:0] data, logic present, logic fin);
      if (present) begin
        if (fill >= 64) begin
          byte_total = byte_total + 64;
          compress(0);
          fill = 0;
        end
        block_buf[fill] = data;
        fill++;
      end
      if (fin) begin
        byte_total = byte_total + fill;
        for (int i = fill; i < 64; i++) block_buf[i] = '0;
        compress(1);
        for (int i = 0; i < 8; i++) begin
          word_q.push_back(chain[i]);
          index_q.push_back(i[2:0]);
        end
        restart();
      end
    endfunction

    function void check_word(logic [31:0] word, logic [2:0] idx, logic lw);
      logic [31:0] exp_word;
      logic [2:0]  exp_idx;
      if (word_q.size() == 0) begin
        $error("digest word %h arrived with nothing pending", word);
        errors++;
        return;
      end
      exp_word = word_q.pop_front();
      exp_idx = index_q.pop_front();
      if (word !== exp_word) begin
        $error("digest_word expected %h actual %h", exp_word, word);
        errors++;
      end
      if (idx !== exp_idx) begin
        $error("word_index expected %0d actual %0d", exp_idx, idx);
        errors++;
      end
      if (lw !== (exp_idx == 3'd7)) begin
        $error("last_word expected %0b actual %0b", exp_idx == 3'd7, lw);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = '0;
  logic        byte_present = 1'b0;
  logic        last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  digest_scoreboard board = new();
  bit stim_done = 0;
  // Set while the receiver deliberately holds off to back the unit up.
  bit hold_off = 0;

  always #5 clk = ~clk;

  blake2s_256_hash_unit i_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .data_byte(data_byte), .byte_present(byte_present), .last(last),
    .out_valid(out_valid), .out_ready(out_ready), .digest_word(digest_word),
    .word_index(word_index), .last_word(last_word)
  );

  // Gap lengths: mostly zero or short, occasionally long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Offer one request and hold it until the unit takes it. Valid stays high
  // across back-to-back requests; it is only lowered when a gap follows.
  task automatic send_request(logic [7:0] data, logic present, logic fin, int gap);
    in_valid <= 1'b1;
    data_byte <= data;
    byte_present <= present;
    last <= fin;
    do @(posedge clk); while (!in_ready);
    board.note_request(data, present, fin);
    if (gap > 0) begin
      in_valid <= 1'b0;
      data_byte <= 8'($urandom);
      byte_present <= 1'($urandom);
      last <= 1'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  // A message of n random bytes, optionally with the final byte merged into
  // the last request and with a few empty requests sprinkled in.
  task automatic send_message(int n, bit merge_last, bit with_gaps);
    for (int i = 0; i < n; i++) begin
      if (with_gaps && $urandom_range(0, 19) == 0)
        send_request(8'($urandom), 1'b0, 1'b0, pick_gap());
      if (merge_last && i == n - 1)
        send_request(8'($urandom), 1'b1, 1'b1, with_gaps ? pick_gap() : 0);
      else
        send_request(8'($urandom), 1'b1, 1'b0, with_gaps ? pick_gap() : 0);
    end
    if (!merge_last || n == 0)
      send_request(8'($urandom), 1'b0, 1'b1, with_gaps ? pick_gap() : 0);
  endtask

  // Receiver: random stalls, compared on every accepted digest word.
  initial begin
    int gap;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready)
        board.check_word(digest_word, word_index, last_word);
      if (hold_off) begin
        out_ready <= 1'b0;
      end else begin
        gap = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap - 1) @(posedge clk);
          out_ready <= 1'b1;
        end else begin
          out_ready <= 1'b1;
        end
      end
    end
  end

  // Stimulus: directed corner cases first, then random messages.
  initial begin
    int sent;
    int n;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Empty message, then a request that carries nothing at all.
    send_request(8'h00, 1'b0, 1'b1, 0);
    send_request(8'hff, 1'b0, 1'b0, 0);
    // One byte merged with last, extreme byte values.
    send_request(8'hff, 1'b1, 1'b1, 0);
    send_request(8'h00, 1'b1, 1'b0, 0);
    send_request(8'hff, 1'b1, 1'b0, 0);
    send_request(8'h00, 1'b0, 1'b1, 2);
    // Exactly one full block, then 65 bytes crossing into a second block.
    send_message(64, 1'b0, 1'b0);
    send_message(65, 1'b1, 1'b0);
    // Long receiver hold-off while the sender keeps offering short messages.
    hold_off = 1;
    fork
      begin
        for (int k = 0; k < 6; k++)
          send_message($urandom_range(0, 4), 1'($urandom), 0);
      end
      begin
        repeat (400) @(posedge clk);
      end
    join_any
    hold_off = 0;
    wait fork;
    sent = 0;
    while (sent < 300) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 130) : $urandom_range(0, 20);
      send_message(n, 1'($urandom), 1'b1);
      sent += n + 1;
    end
    in_valid <= 1'b0;
    stim_done = 1;
  end

  // Drain: wait for all pending words, then a short settle period.
  initial begin
    wait (stim_done);
    while (board.word_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (board.errors == 0 && board.word_q.size() == 0)
      $display("blake2s_256_hash_unit_test: done, clean");
    else
      $display("blake2s_256_hash_unit_test: done, errors");
    $finish;
  end

  initial begin
    #3000000;
    $display("blake2s_256_hash_unit_test: done, errors");
    $finish;
  end

endmodule
